@@ rtl/rwtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rwtc_pkg
// Shared constants and controller/datapath interface types for the
// raycast wall texture column unit.
// ----------------------------------------------------------------------------
package rwtc_pkg;

    localparam int TEX_WIDTH_DEF  = 64;
    localparam int TEX_HEIGHT_DEF = 64;
    localparam int SCREEN_ROWS    = 480;
    localparam int FRAC_BITS      = 16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic load;
        logic tick;
        logic mul;
        logic fin;
    } rwtc_cmd_t;

    typedef struct packed {
        logic div_idle;
        logic out_valid;
    } rwtc_stat_t;

endpackage

@@ rtl/rwtc_div.sv @@
// ----------------------------------------------------------------------------
// rwtc_div
// Restoring divider of a fixed dividend by a 16-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module rwtc_div
    import rwtc_pkg::*;
#(
    parameter int DIVIDEND_W = 23,
    parameter int DIVIDEND   = 4194304
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [15:0]           divisor,
    output logic                  idle,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [CW-1:0]         cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [15:0]           rem_reg;
    logic [15:0]           dsr_reg;
    logic [16:0]           trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= DIVIDEND_W'(DIVIDEND);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
        end
    end

    assign idle     = (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

@@ rtl/rwtc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rwtc_ctrl
// Sequencer: takes items, runs the column set-up (divide, multiply, finish)
// and issues commands to the datapath.
// ----------------------------------------------------------------------------
module rwtc_ctrl
    import rwtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       kind,
    input  logic       out_ready,
    input  rwtc_stat_t stat,
    output logic       in_ready,
    output rwtc_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       take;

    assign in_ready = (state_reg == S_IDLE) && (!stat.out_valid || out_ready);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        cmd.tick = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (stat.div_idle)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/rwtc_datapath.sv @@
// ----------------------------------------------------------------------------
// rwtc_datapath
// Column set-up arithmetic, slice state and the registered pixel output.
// ----------------------------------------------------------------------------
module rwtc_datapath
    import rwtc_pkg::*;
#(
    parameter int TEX_WIDTH  = TEX_WIDTH_DEF,
    parameter int TEX_HEIGHT = TEX_HEIGHT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rwtc_cmd_t          cmd,
    output rwtc_stat_t         stat,
    input  logic [9:0]         column,
    input  logic               wall_side,
    input  logic signed [17:0] dir_x,
    input  logic signed [17:0] dir_y,
    input  logic [23:0]        wall_distance,
    input  logic [23:0]        player_x,
    input  logic [23:0]        player_y,
    input  logic [7:0]         wall_cell,
    input  logic [8:0]         first_row,
    input  logic [8:0]         end_row,
    input  logic [15:0]        slice_height,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [9:0]         out_column,
    output logic [8:0]         row,
    output logic [1:0]         face,
    output logic [5:0]         tex_x,
    output logic [5:0]         tex_y,
    output logic               last
);

    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_SOUTH = 2'd2;
    localparam logic [1:0] FACE_NORTH = 2'd3;

    localparam int DW   = $clog2(TEX_HEIGHT) + FRAC_BITS + 1;
    localparam int TXB  = $clog2(TEX_WIDTH) + 1;
    localparam int TXW  = (TXB > 6) ? TXB : 6;
    localparam int PW   = FRAC_BITS + TXW;
    localparam logic [23:0] HMASK = 24'(TEX_HEIGHT - 1);
    localparam logic [23:0] STEP_MAX = 24'hFFFFFF;

    // captured column inputs
    logic               first_le_reg;
    logic [15:0]        lh_reg;
    logic [8:0]         first_reg;
    logic [23:0]        dist_reg;
    logic signed [17:0] dsel_reg;
    logic [15:0]        pbase_reg;
    logic               mirror_reg;

    // slice state
    logic               busy_reg;
    logic [8:0]         cur_row_reg;
    logic [8:0]         stop_row_reg;
    logic [39:0]        tex_pos_reg;
    logic [23:0]        tex_step_reg;
    logic [5:0]         held_tex_x_reg;
    logic [1:0]         held_face_reg;
    logic [9:0]         held_column_reg;

    // products
    logic signed [42:0] hit_prod_reg;
    logic signed [42:0] pos_prod_reg;

    // output register
    logic               out_valid_reg;
    logic [9:0]         out_column_reg;
    logic [8:0]         row_reg;
    logic [1:0]         face_reg;
    logic [5:0]         tex_x_reg;
    logic [5:0]         tex_y_reg;
    logic               last_reg;

    logic [15:0]        lh_fixed;
    logic               div_idle;
    logic [DW-1:0]      quotient;
    logic [23:0]        step_sat;
    logic [17:0]        a2;
    logic [15:0]        t_low;
    logic [15:0]        frac;
    logic [PW-1:0]      tx_prod;
    logic [TXW-1:0]     tx_raw;
    logic [TXW-1:0]     tx_fin;
    logic [42:0]        pos_half;
    logic [23:0]        whole;
    logic [9:0]         row_inc;
    logic               fin_row;

    assign lh_fixed = (slice_height == 16'd0) ? 16'd1 : slice_height;

    rwtc_div #(
        .DIVIDEND_W (DW),
        .DIVIDEND   (TEX_HEIGHT * (1 << FRAC_BITS))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .divisor  (lh_fixed),
        .idle     (div_idle),
        .quotient (quotient)
    );

    assign step_sat = (quotient > DW'(STEP_MAX)) ? STEP_MAX : 24'(quotient);
    assign a2 = {8'd0, first_reg, 1'b0} - 18'(SCREEN_ROWS) + {2'b00, lh_reg};

    assign t_low   = hit_prod_reg[31:16]
                   + 16'(hit_prod_reg[42] && (hit_prod_reg[15:0] != 16'd0));
    assign frac    = pbase_reg + t_low;
    assign tx_prod = {{TXW{1'b0}}, frac} * PW'(TEX_WIDTH);
    assign tx_raw  = tx_prod[PW-1:FRAC_BITS];
    assign tx_fin  = mirror_reg ? (TXW'(TEX_WIDTH - 1) - tx_raw) : tx_raw;

    assign pos_half = 43'(pos_prod_reg >>> 1)
                    + 43'(pos_prod_reg[42] && pos_prod_reg[0]);

    assign whole   = tex_pos_reg[39:16]
                   + 24'(tex_pos_reg[39] && (tex_pos_reg[15:0] != 16'd0));
    assign row_inc = {1'b0, cur_row_reg} + 10'd1;
    assign fin_row = row_inc >= {1'b0, stop_row_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lh_reg          <= lh_fixed;
            first_reg       <= first_row;
            first_le_reg    <= first_row < end_row;
            dist_reg        <= wall_distance;
            held_column_reg <= column;
            cur_row_reg     <= first_row;
            stop_row_reg    <= end_row;
            if (wall_side == 1'b0)
            begin
                held_face_reg <= ({wall_cell, 16'd0} > player_x) ? FACE_EAST : FACE_WEST;
                dsel_reg      <= dir_y;
                pbase_reg     <= player_y[15:0];
                mirror_reg    <= !dir_x[17] && (dir_x != 18'sd0);
            end
            else
            begin
                held_face_reg <= ({wall_cell, 16'd0} > player_y) ? FACE_SOUTH : FACE_NORTH;
                dsel_reg      <= dir_x;
                pbase_reg     <= player_x[15:0];
                mirror_reg    <= dir_y[17];
            end
        end
        else if (cmd.tick && busy_reg)
        begin
            cur_row_reg <= row_inc[8:0];
        end

        if (cmd.mul)
        begin
            tex_step_reg <= step_sat;
            hit_prod_reg <= $signed({1'b0, dist_reg}) * dsel_reg;
            pos_prod_reg <= $signed(a2) * $signed({1'b0, step_sat});
        end

        if (cmd.fin)
        begin
            tex_pos_reg    <= pos_half[39:0];
            held_tex_x_reg <= tx_fin[5:0];
        end
        else if (cmd.tick && busy_reg)
        begin
            tex_pos_reg <= tex_pos_reg + {16'd0, tex_step_reg};
        end

        if (cmd.tick && busy_reg)
        begin
            out_column_reg <= held_column_reg;
            row_reg        <= cur_row_reg;
            face_reg       <= held_face_reg;
            tex_x_reg      <= held_tex_x_reg;
            tex_y_reg      <= 6'(whole & HMASK);
            last_reg       <= fin_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fin)
            begin
                busy_reg <= first_le_reg;
            end
            else if (cmd.tick && busy_reg && fin_row)
            begin
                busy_reg <= 1'b0;
            end

            if (cmd.tick && busy_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.div_idle  = div_idle;
    assign stat.out_valid = out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign out_column = out_column_reg;
    assign row        = row_reg;
    assign face       = face_reg;
    assign tex_x      = tex_x_reg;
    assign tex_y      = tex_y_reg;
    assign last       = last_reg;

endmodule

@@ rtl/raycast_wall_texture_column_unit.sv @@
// ----------------------------------------------------------------------------
// raycast_wall_texture_column_unit
// Textured wall column for a grid raycaster: loads one ray hit per column and
// emits one texture coordinate per screen row of the wall slice.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): kind 0 loads a column hit, kind 1 is a
//   pixel tick. A tick while no slice is active is taken and dropped.
//   Output channel (out_valid/out_ready): one pixel per tick of an active
//   slice; last is high on the final row.
//   Throughput: ticks are taken one per cycle while the receiver keeps up;
//   each pixel appears in the cycle after its tick is taken, in a registered stage.
//   After a column load in_ready stays low through the set-up: the divide by
//   the bit-serial divider that forms the texture step, whose number of steps
//   is DW = clog2(TEX_HEIGHT) + 17, then the multiplies, then the finish.
//   Stall: while a pixel waits with out_ready low, in_ready stays low.
//   Reset: no slice active, output empty, ready for a load.
// ----------------------------------------------------------------------------
module raycast_wall_texture_column_unit
    import rwtc_pkg::*;
#(
    parameter int TEX_WIDTH  = TEX_WIDTH_DEF,
    parameter int TEX_HEIGHT = TEX_HEIGHT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [9:0]         column,
    input  logic               wall_side,
    input  logic signed [17:0] dir_x,
    input  logic signed [17:0] dir_y,
    input  logic [23:0]        wall_distance,
    input  logic [23:0]        player_x,
    input  logic [23:0]        player_y,
    input  logic [7:0]         wall_cell,
    input  logic [8:0]         first_row,
    input  logic [8:0]         end_row,
    input  logic [15:0]        slice_height,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [9:0]         out_column,
    output logic [8:0]         row,
    output logic [1:0]         face,
    output logic [5:0]         tex_x,
    output logic [5:0]         tex_y,
    output logic               last
);

    rwtc_cmd_t  cmd;
    rwtc_stat_t stat;

    rwtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    rwtc_datapath #(
        .TEX_WIDTH  (TEX_WIDTH),
        .TEX_HEIGHT (TEX_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .column        (column),
        .wall_side     (wall_side),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .wall_distance (wall_distance),
        .player_x      (player_x),
        .player_y      (player_y),
        .wall_cell     (wall_cell),
        .first_row     (first_row),
        .end_row       (end_row),
        .slice_height  (slice_height),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_column    (out_column),
        .row           (row),
        .face          (face),
        .tex_x         (tex_x),
        .tex_y         (tex_y),
        .last          (last)
    );

endmodule

@@ dv/tb_raycast_wall_texture_column_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raycast_wall_texture_column_unit
// Self-checking bench for the wall texture column unit. Column hits and pixel
// ticks go in over a valid/ready channel. A predictor tracks the slice state
// and queues one expected pixel per tick of an active slice. Each pixel that
// comes out is compared field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_raycast_wall_texture_column_unit;
    import rwtc_pkg::*;

    localparam int          TEX_W          = TEX_WIDTH_DEF;
    localparam int          TEX_H          = TEX_HEIGHT_DEF;
    localparam int unsigned LIMIT_CYCLES   = 400000;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned MAX_REPORTS    = 10;

    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_SOUTH = 2'd2;
    localparam logic [1:0] FACE_NORTH = 2'd3;

    typedef struct {
        logic               kind;
        logic [9:0]         column;
        logic               wall_side;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic [23:0]        wall_distance;
        logic [23:0]        player_x;
        logic [23:0]        player_y;
        logic [7:0]         wall_cell;
        logic [8:0]         first_row;
        logic [8:0]         end_row;
        logic [15:0]        slice_height;
    } ray_item_t;

    typedef struct packed {
        logic [9:0] out_column;
        logic [8:0] row;
        logic [1:0] face;
        logic [5:0] tex_x;
        logic [5:0] tex_y;
        logic       last;
    } pixel_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [9:0]         column;
    logic               wall_side;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic [23:0]        wall_distance;
    logic [23:0]        player_x;
    logic [23:0]        player_y;
    logic [7:0]         wall_cell;
    logic [8:0]         first_row;
    logic [8:0]         end_row;
    logic [15:0]        slice_height;
    logic               out_valid;
    logic               out_ready;
    logic [9:0]         out_column;
    logic [8:0]         row;
    logic [1:0]         face;
    logic [5:0]         tex_x;
    logic [5:0]         tex_y;
    logic               last;

    logic        slice_active;
    logic [8:0]  slice_row;
    logic [8:0]  slice_stop;
    longint      tex_pos_q;
    logic [23:0] tex_step_q;
    logic [5:0]  col_tex_x;
    logic [1:0]  col_face;
    logic [9:0]  col_column;

    pixel_t      pixels_due[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    logic        tx_burst;
    logic        rx_hold;
    event        rx_hold_ev;

    raycast_wall_texture_column_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .column        (column),
        .wall_side     (wall_side),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .wall_distance (wall_distance),
        .player_x      (player_x),
        .player_y      (player_y),
        .wall_cell     (wall_cell),
        .first_row     (first_row),
        .end_row       (end_row),
        .slice_height  (slice_height),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_column    (out_column),
        .row           (row),
        .face          (face),
        .tex_x         (tex_x),
        .tex_y         (tex_y),
        .last          (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint shift_toward_zero(longint v, int unsigned sh);
        if (v < 0)
            return -((-v) >> sh);
        return v >> sh;
    endfunction

    function automatic longint wrap_pos(longint v);
        logic signed [39:0] w;
        w = v[39:0];
        return w;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ray_item_t noise_item();
        ray_item_t it;
        it.kind          = 1'($urandom_range(0, 1));
        it.column        = 10'($urandom);
        it.wall_side     = 1'($urandom);
        it.dir_x         = 18'($urandom);
        it.dir_y         = 18'($urandom);
        it.wall_distance = 24'($urandom);
        it.player_x      = 24'($urandom);
        it.player_y      = 24'($urandom);
        it.wall_cell     = 8'($urandom);
        it.first_row     = 9'($urandom);
        it.end_row       = 9'($urandom);
        it.slice_height  = 16'($urandom);
        return it;
    endfunction

    function automatic ray_item_t tick_item();
        ray_item_t it;
        it      = noise_item();
        it.kind = KIND_TICK;
        return it;
    endfunction

    function automatic ray_item_t load_item(int col, int side, int dx, int dy, int wdist,
                                            int px, int py, int wcell, int first, int stop,
                                            int lh);
        ray_item_t it;
        it.kind          = KIND_LOAD;
        it.column        = 10'(col);
        it.wall_side     = 1'(side);
        it.dir_x         = 18'(dx);
        it.dir_y         = 18'(dy);
        it.wall_distance = 24'(wdist);
        it.player_x      = 24'(px);
        it.player_y      = 24'(py);
        it.wall_cell     = 8'(wcell);
        it.first_row     = 9'(first);
        it.end_row       = 9'(stop);
        it.slice_height  = 16'(lh);
        return it;
    endfunction

    function automatic ray_item_t random_load();
        ray_item_t   it;
        int unsigned r;
        int unsigned len;
        int unsigned stop;
        it      = noise_item();
        it.kind = KIND_LOAD;
        if ($urandom_range(0, 3) == 0)
            it.wall_distance = 24'($urandom_range(0, 24'h03FFFF));
        if ($urandom_range(0, 9) == 0)
            it.dir_x = '0;
        if ($urandom_range(0, 9) == 0)
            it.dir_y = '0;
        if ($urandom_range(0, 9) == 0)
            it.player_x = {it.wall_cell, 16'h0000};
        if ($urandom_range(0, 9) == 0)
            it.player_y = {it.wall_cell, 16'h0000};
        r = $urandom_range(0, 9);
        if (r < 7)
            it.slice_height = 16'($urandom_range(1, 600));
        else if (r < 9)
            it.slice_height = 16'($urandom_range(600, 4000));
        it.first_row = 9'($urandom_range(0, 480));
        r = $urandom_range(0, 99);
        if (r < 3)
            len = 0;
        else if (r < 6)
            len = $urandom_range(17, 480);
        else
            len = $urandom_range(1, 16);
        stop = int'(it.first_row) + len;
        if (stop > 511)
            stop = 511;
        it.end_row = 9'(stop);
        if (r == 0)
            it.end_row = 9'($urandom_range(0, int'(it.first_row)));
        return it;
    endfunction

    task automatic predict_texel(input ray_item_t it);
        longint      dx, dy, wdist, px, py, cellq, hit, a2, q, lh, whole;
        int unsigned tx;
        logic        fin;
        pixel_t      pix;
        if (it.kind == KIND_LOAD)
        begin
            dx    = longint'(it.dir_x);
            dy    = longint'(it.dir_y);
            wdist = longint'(it.wall_distance);
            px    = longint'(it.player_x);
            py    = longint'(it.player_y);
            cellq = longint'(it.wall_cell) << FRAC_BITS;
            if (it.wall_side == 1'b0)
            begin
                col_face = (cellq > px) ? FACE_EAST : FACE_WEST;
                hit      = py + shift_toward_zero(wdist * dy, FRAC_BITS);
            end
            else
            begin
                col_face = (cellq > py) ? FACE_SOUTH : FACE_NORTH;
                hit      = px + shift_toward_zero(wdist * dx, FRAC_BITS);
            end
            tx = (int'(hit[15:0]) * TEX_W) >> FRAC_BITS;
            if ((it.wall_side == 1'b0 && dx > 0) || (it.wall_side == 1'b1 && dy < 0))
                tx = TEX_W - 1 - tx;
            col_tex_x = tx[5:0];
            lh = longint'(it.slice_height);
            if (lh == 0)
                lh = 1;
            q = (longint'(TEX_H) << FRAC_BITS) / lh;
            if (q > 64'hFFFFFF)
                q = 64'hFFFFFF;
            tex_step_q   = q[23:0];
            a2           = 2 * longint'(it.first_row) - SCREEN_ROWS + lh;
            tex_pos_q    = wrap_pos(shift_toward_zero(a2 * q, 1));
            col_column   = it.column;
            slice_row    = it.first_row;
            slice_stop   = it.end_row;
            slice_active = it.first_row < it.end_row;
        end
        else if (slice_active)
        begin
            whole          = shift_toward_zero(tex_pos_q, FRAC_BITS);
            fin            = ({1'b0, slice_row} + 10'd1) >= {1'b0, slice_stop};
            pix.out_column = col_column;
            pix.row        = slice_row;
            pix.face       = col_face;
            pix.tex_x      = col_tex_x;
            pix.tex_y      = 6'(whole & longint'(TEX_H - 1));
            pix.last       = fin;
            pixels_due.push_back(pix);
            tex_pos_q = wrap_pos(tex_pos_q + longint'(tex_step_q));
            slice_row = slice_row + 9'd1;
            if (fin)
                slice_active = 1'b0;
        end
    endtask

    task automatic send_item(input ray_item_t it);
        int unsigned gap;
        gap = tx_burst ? 0 : idle_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        kind          = it.kind;
        column        = it.column;
        wall_side     = it.wall_side;
        dir_x         = it.dir_x;
        dir_y         = it.dir_y;
        wall_distance = it.wall_distance;
        player_x      = it.player_x;
        player_y      = it.player_y;
        wall_cell     = it.wall_cell;
        first_row     = it.first_row;
        end_row       = it.end_row;
        slice_height  = it.slice_height;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_texel(it);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_pixel(input string why, input pixel_t want, input pixel_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t %s: exp col %0d row %0d face %0d tx %0d ty %0d last %0d", $realtime,
                     why, want.out_column, want.row, want.face, want.tex_x, want.tex_y,
                     want.last);
            $display("    got col %0d row %0d face %0d tx %0d ty %0d last %0d",
                     got.out_column, got.row, got.face, got.tex_x, got.tex_y, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {out_column, row, face, tex_x, tex_y, last};
            if (pixels_due.size() == 0)
                flag_pixel("unexpected pixel", '0, got);
            else
            begin
                want = pixels_due.pop_front();
                if (got.out_column !== want.out_column || got.row !== want.row ||
                    got.face !== want.face || got.tex_x !== want.tex_x ||
                    got.tex_y !== want.tex_y || got.last !== want.last)
                    flag_pixel("pixel mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(rx_hold_ev);
            @(posedge clk);
            rx_hold = 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    initial
    begin
        int unsigned stall_left;
        int unsigned run_left;
        stall_left = 0;
        run_left   = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
                out_ready = 1'b0;
            else if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                out_ready = 1'b1;
                run_left--;
            end
            else
            begin
                out_ready = 1'b1;
                case ($urandom_range(0, 9))
                    0, 1:    stall_left = idle_gap() + 1;
                    2:       run_left = $urandom_range(40, 150);
                    default: ;
                endcase
            end
        end
    end

    task automatic test_directed_columns();
        send_item(tick_item());
        send_item(load_item(1023, 0, 131071, -131072, 24'hFFFFFF, 0, 24'hFFFFFF, 255,
                            0, 2, 65535));
        repeat (2) send_item(tick_item());
        send_item(load_item(0, 0, -131072, 131071, 24'h010000, 24'hFFFFFF, 24'h008000, 0,
                            479, 480, 1));
        repeat (2) send_item(tick_item());
        send_item(load_item(512, 1, 131071, -1, 24'h020000, 24'h123456, 0, 4,
                            10, 12, 0));
        repeat (2) send_item(tick_item());
        send_item(load_item(77, 1, -131072, 131071, 24'h00C000, 1, 24'h050000, 5,
                            20, 24, 480));
        send_item(tick_item());
        // replace the slice in progress; rows run past the screen
        send_item(load_item(300, 0, 0, 0, 0, 24'h030000, 24'h0000FF, 3, 500, 511, 200));
        repeat (2) send_item(tick_item());
        send_item(load_item(5, 1, 0, 0, 0, 0, 0, 0, 100, 100, 64));
        send_item(tick_item());
        send_item(load_item(6, 0, 0, 0, 0, 0, 0, 0, 300, 5, 64));
        send_item(tick_item());
        wait_for_drain();
    endtask

    task automatic test_output_stall();
        ray_item_t it;
        wait_for_drain();
        -> rx_hold_ev;
        it           = random_load();
        it.first_row = 100;
        it.end_row   = 160;
        send_item(it);
        repeat (60) send_item(tick_item());
        wait_for_drain();
    endtask

    task automatic test_random_slices(input int unsigned budget);
        ray_item_t   it;
        int unsigned taken;
        int unsigned rows;
        int unsigned n;
        taken = 0;
        while (taken < budget)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_burst = !tx_burst;
            if ($urandom_range(0, 59) == 0)
                wait_for_drain();
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(noise_item());
                taken++;
                continue;
            end
            it = random_load();
            send_item(it);
            taken++;
            rows = (it.end_row > it.first_row) ?
                   int'(it.end_row) - int'(it.first_row) : 0;
            case ($urandom_range(0, 9))
                0:       n = rows / 2;
                1:       n = rows + $urandom_range(1, 3);
                default: n = rows;
            endcase
            repeat (n) send_item(tick_item());
            taken += (n < rows) ? n : rows;
        end
        tx_burst = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_TICK;
        column         = '0;
        wall_side      = 1'b0;
        dir_x          = '0;
        dir_y          = '0;
        wall_distance  = '0;
        player_x       = '0;
        player_y       = '0;
        wall_cell      = '0;
        first_row      = '0;
        end_row        = '0;
        slice_height   = '0;
        slice_active   = 1'b0;
        slice_row      = '0;
        slice_stop     = '0;
        tex_pos_q      = 0;
        tex_step_q     = '0;
        col_tex_x      = '0;
        col_face       = FACE_EAST;
        col_column     = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_burst       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed_columns();
        test_random_slices(300);
        test_output_stall();
        test_random_slices(320);

        wait_for_drain();
        repeat (64) @(posedge clk);
        if (mismatch_count == 0 && pixels_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ raycast_wall_texture_column_unit.f @@
rtl/rwtc_pkg.sv
rtl/rwtc_div.sv
rtl/rwtc_ctrl.sv
rtl/rwtc_datapath.sv
rtl/raycast_wall_texture_column_unit.sv
dv/tb_raycast_wall_texture_column_unit.sv
